[hw/rtl/mandelbrot_escape_color_pixel_defines.svh]
// ---------------------------------------------------------------------------
// mandelbrot_escape_color_pixel_defines.svh
// Assertion macros shared by the escape-time pixel block.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_COLOR_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_COLOR_PIXEL_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define MEBC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define MEBC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/mebc_pkg.sv]
// ---------------------------------------------------------------------------
// mebc_pkg
// Types and constants of the escape-time pixel block.
// ---------------------------------------------------------------------------
package mebc_pkg;

	// Coordinate format: signed, 28 fraction bits
	localparam int COORD_W = 32;
	localparam int FRAC_W  = 28;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int ITER_W  = 12;
	localparam int GAIN_W  = 8;
	localparam int IDX_W   = 12;
	localparam int CFG_IDX_W = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN   = 3'd7;

	// Escape box |z| component bound 3.0 and its square 9.0 (56 fraction bits)
	localparam logic signed [COORD_W-1:0] BOUND     = 32'sh3000_0000;
	localparam logic signed [COORD_W-1:0] NEG_BOUND = 32'shD000_0000;
	localparam logic [PROD_W:0]           BOUND_SQ  = 65'h0_0900_0000_0000_0000;

	localparam logic [7:0] WHITE = 8'hFF;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       escaped;
	} color_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_real;
		logic signed [COORD_W-1:0] origin_imag;
		logic signed [COORD_W-1:0] step_real;
		logic signed [COORD_W-1:0] step_imag;
		logic [ITER_W-1:0]         iteration_limit;
		logic [GAIN_W-1:0]         red_gain;
		logic [GAIN_W-1:0]         green_gain;
		logic [GAIN_W-1:0]         blue_gain;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_R,
		ST_MAP_I,
		ST_MUL_XX,
		ST_MUL_YY,
		ST_MUL_XY,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/mebc_mul.sv]
// ---------------------------------------------------------------------------
// mebc_mul
// Shared signed 32x32 multiplier with registered 64-bit product.
// ---------------------------------------------------------------------------
module mebc_mul import mebc_pkg::*; (
	input  logic                      clk,
	input  logic signed [COORD_W-1:0] a,
	input  logic signed [COORD_W-1:0] b,
	output logic signed [PROD_W-1:0]  p
);

	logic signed [PROD_W-1:0] p_q;

	// one product per cycle, full precision
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

[hw/rtl/mebc_core.sv]
// ---------------------------------------------------------------------------
// mebc_core
// Sequencer and datapath: maps a pixel to c, iterates z = z*z + c on the
// shared multiplier, and holds the color result for the output channel.
// ---------------------------------------------------------------------------
`include "mandelbrot_escape_color_pixel_defines.svh"

module mebc_core import mebc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   pixel_valid,
	output logic   pixel_stall,
	input  pixel_t pixel,
	output logic   color_valid,
	input  logic   color_stall,
	output color_t color
);

	state_t state_q, state_d;

	logic [IDX_W-1:0]          col_q, row_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, zx_q, zy_q;
	logic signed [PROD_W-1:0]  sqx_q, sqy_q;
	logic [ITER_W-1:0]         d_q;
	logic                      first_q;
	logic                      esc_q;
	logic                      color_valid_q;
	color_t                    color_q;

	logic signed [COORD_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;

	logic signed [PROD_W:0]    diff;
	logic signed [COORD_W-1:0] nx, ny;
	logic [PROD_W:0]           mag_sq;
	logic                      box_out, sq_out, limit_hit;
	logic                      accept, load_out;

	// saturate a wide sum to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [PROD_W+1:0] v
	);
		logic fits;
		fits = (v[PROD_W+1:COORD_W-1] == {(PROD_W-COORD_W+3){v[PROD_W+1]}});
		if (fits)
			return v[COORD_W-1:0];
		else if (v[PROD_W+1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	// shared multiplier and its operand select
	mebc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_comb begin
		unique case (state_q)
			ST_MAP_R: begin
				mul_a = cfg.step_real;
				mul_b = $signed({{(COORD_W-IDX_W){1'b0}}, col_q});
			end
			ST_MAP_I: begin
				mul_a = cfg.step_imag;
				mul_b = $signed({{(COORD_W-IDX_W){1'b0}}, row_q});
			end
			ST_MUL_XX: begin
				mul_a = zx_q;
				mul_b = zx_q;
			end
			ST_MUL_YY: begin
				mul_a = zy_q;
				mul_b = zy_q;
			end
			default: begin
				mul_a = zx_q;
				mul_b = zy_q;
			end
		endcase
	end

	// next z from the stored squares and the cross product on the unit output
	assign diff = (PROD_W+1)'(sqx_q) - (PROD_W+1)'(sqy_q);
	assign nx = sat_coord((PROD_W+2)'(diff >>> FRAC_W) + (PROD_W+2)'(cx_q));
	assign ny = sat_coord((PROD_W+2)'(prod >>> (FRAC_W - 1)) + (PROD_W+2)'(cy_q));
	assign box_out = (nx > BOUND) || (nx < NEG_BOUND) || (ny > BOUND) || (ny < NEG_BOUND);

	// magnitude test: zx^2 held, zy^2 on the unit output
	assign mag_sq = {1'b0, sqx_q} + {1'b0, prod};
	assign sq_out = mag_sq > BOUND_SQ;

	assign limit_hit = (d_q == cfg.iteration_limit);
	assign accept = pixel_valid && (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!color_valid_q || !color_stall);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (pixel_valid) state_d = ST_MAP_R;
			ST_MAP_R:  state_d = ST_MAP_I;
			ST_MAP_I:  state_d = ST_MUL_XX;
			ST_MUL_XX: state_d = ST_MUL_YY;
			ST_MUL_YY: state_d = ST_MUL_XY;
			ST_MUL_XY: begin
				if (!first_q && sq_out)
					state_d = ST_DONE;
				else
					state_d = ST_UPD;
			end
			ST_UPD: begin
				if (limit_hit || box_out)
					state_d = ST_DONE;
				else
					state_d = ST_MUL_XX;
			end
			ST_DONE:   if (load_out) state_d = ST_IDLE;
		endcase
	end

	// iteration datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					col_q   <= pixel.column;
					row_q   <= pixel.row;
					zx_q    <= '0;
					zy_q    <= '0;
					d_q     <= '0;
					first_q <= 1'b1;
					esc_q   <= 1'b0;
				end
			end
			ST_MAP_R: ;
			ST_MAP_I: cx_q <= sat_coord((PROD_W+2)'(prod) + (PROD_W+2)'(cfg.origin_real));
			ST_MUL_XX: begin
				if (first_q)
					cy_q <= sat_coord((PROD_W+2)'(prod) + (PROD_W+2)'(cfg.origin_imag));
			end
			ST_MUL_YY: sqx_q <= prod;
			ST_MUL_XY: begin
				sqy_q <= prod;
				if (!first_q) begin
					if (sq_out)
						esc_q <= 1'b1;
					else
						d_q <= d_q + 1'b1;
				end
			end
			ST_UPD: begin
				if (!limit_hit) begin
					zx_q    <= nx;
					zy_q    <= ny;
					first_q <= 1'b0;
					esc_q   <= box_out;
				end
			end
			ST_DONE: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_valid_q <= 1'b0;
		end else if (load_out) begin
			color_valid_q <= 1'b1;
		end else if (!color_stall) begin
			color_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (esc_q) begin
				color_q.blue    <= 8'(d_q[7:0] * cfg.blue_gain);
				color_q.green   <= 8'(d_q[7:0] * cfg.green_gain);
				color_q.red     <= 8'(d_q[7:0] * cfg.red_gain);
				color_q.escaped <= 1'b1;
			end else begin
				color_q.blue    <= WHITE;
				color_q.green   <= WHITE;
				color_q.red     <= WHITE;
				color_q.escaped <= 1'b0;
			end
		end
	end

	assign pixel_stall = (state_q != ST_IDLE);
	assign color_valid = color_valid_q;
	assign color       = color_q;

	// checks
	`MEBC_ASSERT_CLK(a_accept_starts, accept |=> state_q == ST_MAP_R, "accepted pixel did not start mapping")
	`MEBC_ASSERT_CLK(a_round_bound, state_q != ST_IDLE |-> d_q <= cfg.iteration_limit, "round count passed limit")
	`MEBC_ASSERT_CLK(a_z_in_box, state_q == ST_UPD |-> (zx_q <= BOUND) && (zx_q >= NEG_BOUND) && (zy_q <= BOUND) && (zy_q >= NEG_BOUND), "z outside escape box at update")
	`MEBC_ASSERT_CLK(a_done_waits, (state_q == ST_DONE) && color_valid_q && color_stall |=> state_q == ST_DONE, "result dropped while output held")
	`MEBC_ASSERT_RST(a_reset_empty, !arst_n |-> !color_valid_q && (state_q == ST_IDLE), "output or sequencer not cleared in reset")

endmodule

[hw/rtl/mandelbrot_escape_color_pixel.sv]
// ---------------------------------------------------------------------------
// mandelbrot_escape_color_pixel
// Escape-time coloring of one pixel in fixed point, with configuration
// registers and one shared multiplier under a small sequencer.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  pixel    in         pixel_valid / pixel_stall  pixel_t  (column, row)
//  color    out        color_valid / color_stall  color_t  (blue, green, red, escaped)
//  cfg      in         cfg_we                     cfg_index, cfg_wdata
//
//  A color is produced once a point stays bounded up to the limit L, leaves
//  the +/-3 box in round d, or is caught only by |z|^2 > 9. A round is three
//  products on the one 32x32 multiplier plus an update. The input stalls until
//  the sequencer is idle again, which it becomes as the result enters the output
//  register; the result waits there while the next pixel starts. Reset clears
//  the sequencer and the output valid and loads register defaults.
// ---------------------------------------------------------------------------
module mandelbrot_escape_color_pixel import mebc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  pixel_t               pixel,
	output logic                 color_valid,
	input  logic                 color_stall,
	output color_t               color,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata
);

	cfg_t cfg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real     <= -32'sd536870912;
			cfg_q.origin_imag     <= -32'sd268435456;
			cfg_q.step_real       <= 32'sd2097152;
			cfg_q.step_imag       <= 32'sd2097152;
			cfg_q.iteration_limit <= 12'd256;
			cfg_q.red_gain        <= 8'd1;
			cfg_q.green_gain      <= 8'd1;
			cfg_q.blue_gain       <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_REAL: cfg_q.origin_real     <= $signed(cfg_wdata);
				REG_ORIGIN_IMAG: cfg_q.origin_imag     <= $signed(cfg_wdata);
				REG_STEP_REAL:   cfg_q.step_real       <= $signed(cfg_wdata);
				REG_STEP_IMAG:   cfg_q.step_imag       <= $signed(cfg_wdata);
				REG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_wdata[ITER_W-1:0];
				REG_RED_GAIN:    cfg_q.red_gain        <= cfg_wdata[GAIN_W-1:0];
				REG_GREEN_GAIN:  cfg_q.green_gain      <= cfg_wdata[GAIN_W-1:0];
				REG_BLUE_GAIN:   cfg_q.blue_gain       <= cfg_wdata[GAIN_W-1:0];
			endcase
		end
	end

	// iteration core
	mebc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.color       (color)
	);

endmodule

[sim/mebc_color_checker.sv]
// ---------------------------------------------------------------------------
// mebc_color_checker
// Watches the pixel, color and register-write ports of the escape-time
// block. Keeps its own image of the registers, predicts the color of every
// accepted pixel transaction and compares each color transaction, field by
// field, against the oldest prediction still owed.
// ---------------------------------------------------------------------------
module mebc_color_checker import mebc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	input  logic                 pixel_stall,
	input  pixel_t               pixel,
	input  logic                 color_valid,
	input  logic                 color_stall,
	input  color_t               color,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata,
	output int unsigned          mismatches,
	output int unsigned          colors_owed,
	output int unsigned          colors_seen,
	output int unsigned          colors_escaped
);
	timeunit 1ns;
	timeprecision 1ps;

	// Coordinate range and escape box with FRAC_W fraction bits, its square with 2*FRAC_W
	localparam longint COORD_HI   = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam longint COORD_LO   = -COORD_HI - 64'sd1;
	localparam longint ESC_BOX    = 64'sd3 <<< FRAC_W;
	localparam longint ESC_BOX_SQ = ESC_BOX * ESC_BOX;
	localparam int     ROUND_CAP  = 4095;
	localparam int     PRINT_CAP  = 40;

	localparam cfg_t RESET_REGS = {32'hE000_0000, 32'hF000_0000, 32'h0020_0000,
		32'h0020_0000, 12'd256, 8'd1, 8'd1, 8'd1};

	cfg_t   regs;
	color_t owed[$];
	color_t want;

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI)
			return COORD_HI;
		if (v < COORD_LO)
			return COORD_LO;
		return v;
	endfunction

	// Escape-time color of one pixel under a given register image
	function automatic color_t escape_color(input cfg_t r, input pixel_t px);
		longint      cx, cy, zx, zy, nx;
		int          rounds, d;
		logic        fled;
		logic [31:0] scaled;
		color_t      c;
		cx = clamp_coord(longint'(r.origin_real) +
			longint'(r.step_real) * longint'(px.column));
		cy = clamp_coord(longint'(r.origin_imag) +
			longint'(r.step_imag) * longint'(px.row));
		rounds = r.iteration_limit;
		if (rounds > ROUND_CAP)
			rounds = ROUND_CAP;
		zx = 0;
		zy = 0;
		d = 0;
		fled = 1'b0;
		while (!fled && d < rounds) begin
			// >>> on a signed value floors the rescale
			nx = clamp_coord(((zx * zx - zy * zy) >>> FRAC_W) + cx);
			zy = clamp_coord(((2 * zx * zy) >>> FRAC_W) + cy);
			zx = nx;
			// box test first: outside it the squares could overflow
			if (zx > ESC_BOX || zx < -ESC_BOX || zy > ESC_BOX || zy < -ESC_BOX)
				fled = 1'b1;
			else if (zx * zx + zy * zy > ESC_BOX_SQ)
				fled = 1'b1;
			else
				d++;
		end
		if (fled) begin
			scaled = d * r.blue_gain;
			c.blue = scaled[7:0];
			scaled = d * r.green_gain;
			c.green = scaled[7:0];
			scaled = d * r.red_gain;
			c.red = scaled[7:0];
			c.escaped = 1'b1;
		end else begin
			c.blue = WHITE;
			c.green = WHITE;
			c.red = WHITE;
			c.escaped = 1'b0;
		end
		return c;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Monitor: results leave first, then new pixels and register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = RESET_REGS;
			owed.delete();
			mismatches = 0;
			colors_owed = 0;
			colors_seen = 0;
			colors_escaped = 0;
		end else begin
			if (color_valid && !color_stall) begin
				if (owed.size() == 0) begin
					flag_mismatch("color transaction with no pixel outstanding");
				end else begin
					want = owed.pop_front();
					if (color.blue !== want.blue)
						flag_mismatch($sformatf("color %0d blue %0d, predicted %0d",
							colors_seen, color.blue, want.blue));
					if (color.green !== want.green)
						flag_mismatch($sformatf("color %0d green %0d, predicted %0d",
							colors_seen, color.green, want.green));
					if (color.red !== want.red)
						flag_mismatch($sformatf("color %0d red %0d, predicted %0d",
							colors_seen, color.red, want.red));
					if (color.escaped !== want.escaped)
						flag_mismatch($sformatf("color %0d escaped %0b, predicted %0b",
							colors_seen, color.escaped, want.escaped));
					colors_seen++;
					if (want.escaped)
						colors_escaped++;
				end
			end
			if (pixel_valid && !pixel_stall)
				owed.push_back(escape_color(regs, pixel));
			if (cfg_we) begin
				case (cfg_index)
					REG_ORIGIN_REAL: regs.origin_real = cfg_wdata;
					REG_ORIGIN_IMAG: regs.origin_imag = cfg_wdata;
					REG_STEP_REAL:   regs.step_real = cfg_wdata;
					REG_STEP_IMAG:   regs.step_imag = cfg_wdata;
					REG_ITER_LIMIT:  regs.iteration_limit = cfg_wdata[ITER_W-1:0];
					REG_RED_GAIN:    regs.red_gain = cfg_wdata[GAIN_W-1:0];
					REG_GREEN_GAIN:  regs.green_gain = cfg_wdata[GAIN_W-1:0];
					REG_BLUE_GAIN:   regs.blue_gain = cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end
			colors_owed = owed.size();
		end
	end

endmodule

[sim/tb_mandelbrot_escape_color_pixel.sv]
// ---------------------------------------------------------------------------
// tb_mandelbrot_escape_color_pixel
// Drives pixel transactions and register settings into the escape-time
// block: a directed pass over reset values, iteration limits of zero, one
// and the maximum, saturating coordinates and extreme gains, a long output
// hold-off, then random views of the plane under three idling patterns.
// Checking is done by mebc_color_checker; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_mandelbrot_escape_color_pixel;
	timeunit 1ns;
	timeprecision 1ps;
	import mebc_pkg::*;

	localparam int HOLD_CYCLES      = 1500;
	localparam int RANDOM_PER_PHASE = 450;

	localparam cfg_t DEFAULT_VIEW = {32'hE000_0000, 32'hF000_0000, 32'h0020_0000,
		32'h0020_0000, 12'd256, 8'd1, 8'd1, 8'd1};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 pixel_valid;
	logic                 pixel_stall;
	pixel_t               pixel;
	logic                 color_valid;
	logic                 color_stall;
	color_t               color;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_wdata;

	int unsigned mismatches, colors_owed, colors_seen, colors_escaped;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned settings = 1;
	logic        hold_req = 1'b0;

	mandelbrot_escape_color_pixel dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.color       (color),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	mebc_color_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.pixel          (pixel),
		.color_valid    (color_valid),
		.color_stall    (color_stall),
		.color          (color),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.colors_owed    (colors_owed),
		.colors_seen    (colors_seen),
		.colors_escaped (colors_escaped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("FAIL mandelbrot_escape_color_pixel");
		$finish;
	end

	// Color receiver: random stall, plus one long hold-off on request
	initial begin
		color_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					color_stall <= 1'b1;
					@(posedge clk);
				end
			end
			color_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// One pixel transaction; valid stays high afterwards until the next gap
	task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
		pixel_t px;
		px.column = col;
		px.row = row;
		if ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (pixel_stall);
	endtask

	// Drop valid and wait until every owed color has come back
	task automatic settle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (colors_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all eight registers; upper bits of the narrow ones carry junk
	task automatic program_view(input cfg_t v);
		logic [COORD_W-1:0] junk;
		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= REG_ORIGIN_REAL;
		cfg_wdata <= v.origin_real;
		@(posedge clk);
		cfg_index <= REG_ORIGIN_IMAG;
		cfg_wdata <= v.origin_imag;
		@(posedge clk);
		cfg_index <= REG_STEP_REAL;
		cfg_wdata <= v.step_real;
		@(posedge clk);
		cfg_index <= REG_STEP_IMAG;
		cfg_wdata <= v.step_imag;
		@(posedge clk);
		cfg_index <= REG_ITER_LIMIT;
		cfg_wdata <= {junk[COORD_W-1:ITER_W], v.iteration_limit};
		@(posedge clk);
		cfg_index <= REG_RED_GAIN;
		cfg_wdata <= {junk[COORD_W-1:GAIN_W], v.red_gain};
		@(posedge clk);
		cfg_index <= REG_GREEN_GAIN;
		cfg_wdata <= {junk[COORD_W-1:GAIN_W], v.green_gain};
		@(posedge clk);
		cfg_index <= REG_BLUE_GAIN;
		cfg_wdata <= {junk[COORD_W-1:GAIN_W], v.blue_gain};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return IDX_W'($urandom_range(4095));
		endcase
	endfunction

	// Stimulus
	initial begin
		cfg_t view;
		int   phase, kind, batch, sent;
		arst_n <= 1'b0;
		pixel_valid <= 1'b0;
		pixel <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: corners, the origin of the set, and two
		// points whose orbit saturates the real part high and low
		send_pixel(0, 0);
		send_pixel(256, 128);
		send_pixel(4095, 4095);
		send_pixel(4095, 0);
		send_pixel(0, 4095);
		send_pixel(627, 128);
		send_pixel(256, 499);

		// No rounds at all: everything is white
		settle();
		view = DEFAULT_VIEW;
		view.iteration_limit = '0;
		view.red_gain = 8'd255;
		view.green_gain = 8'd255;
		view.blue_gain = 8'd255;
		program_view(view);
		send_pixel(256, 128);
		send_pixel(0, 0);

		// Single round
		settle();
		view.iteration_limit = 12'd1;
		program_view(view);
		send_pixel(0, 0);
		send_pixel(4095, 4095);

		// Largest limit, mixed gains
		settle();
		view.iteration_limit = '1;
		view.red_gain = 8'd255;
		view.green_gain = 8'd7;
		view.blue_gain = 8'd3;
		program_view(view);
		send_pixel(256, 128);
		send_pixel(289, 128);
		send_pixel(2, 140);

		// Mapping overflows in both directions, with zero gains and then mixed gains
		settle();
		view.origin_real = 32'h7FFF_FFFF;
		view.origin_imag = 32'h8000_0000;
		view.step_real = 32'h7FFF_FFFF;
		view.step_imag = 32'h8000_0000;
		view.iteration_limit = 12'd16;
		view.red_gain = 8'd0;
		view.green_gain = 8'd0;
		view.blue_gain = 8'd0;
		program_view(view);
		send_pixel(4095, 4095);
		send_pixel(0, 0);
		send_pixel(1, 1);
		settle();
		view.origin_real = 32'h8000_0000;
		view.origin_imag = 32'h7FFF_FFFF;
		view.step_real = 32'h8000_0000;
		view.step_imag = 32'h7FFF_FFFF;
		view.red_gain = 8'd1;
		view.green_gain = 8'd2;
		view.blue_gain = 8'd255;
		program_view(view);
		send_pixel(4095, 4095);
		send_pixel(2048, 1);

		// Long output hold-off: the block fills and stalls its input
		settle();
		view = DEFAULT_VIEW;
		view.iteration_limit = 12'd8;
		view.green_gain = 8'd37;
		program_view(view);
		hold_req = 1'b1;
		repeat (12)
			send_pixel(pick_index(), pick_index());

		// Random views under three idling patterns
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 86 : 0;
			recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 8 : 0;
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				settle();
				kind = $urandom_range(9);
				if (kind < 5) begin
					// whole set, slightly jittered
					view.origin_real = 32'hD800_0000 + $urandom_range(32'hFFFFF);
					view.origin_imag = 32'hE800_0000 + $urandom_range(32'hFFFFF);
					view.step_real = 229376 + $urandom_range(4096);
					view.step_imag = 196608 + $urandom_range(4096);
				end else if (kind < 9) begin
					// zoom somewhere near the set, either orientation
					view.origin_real = 32'hD800_0000 + $urandom_range(32'h3800_0000);
					view.origin_imag = 32'hE800_0000 + $urandom_range(32'h3000_0000);
					view.step_real = $urandom_range(1, 16384);
					view.step_imag = $urandom_range(1, 16384);
					if ($urandom_range(1))
						view.step_real = -view.step_real;
					if ($urandom_range(1))
						view.step_imag = -view.step_imag;
				end else begin
					view.origin_real = $urandom;
					view.origin_imag = $urandom;
					view.step_real = $urandom;
					view.step_imag = $urandom;
				end
				case ($urandom_range(9))
					0: view.iteration_limit = ITER_W'($urandom_range(100, 300));
					1, 2: view.iteration_limit = ITER_W'($urandom_range(8));
					default: view.iteration_limit = ITER_W'($urandom_range(9, 64));
				endcase
				view.red_gain = GAIN_W'($urandom_range(255));
				view.green_gain = GAIN_W'($urandom_range(255));
				view.blue_gain = GAIN_W'($urandom_range(255));
				program_view(view);
				batch = $urandom_range(15, 60);
				repeat (batch)
					send_pixel(pick_index(), pick_index());
				sent += batch;
			end
		end

		settle();
		repeat (64) @(posedge clk);
		$display("Colored %0d pixels over %0d register settings: %0d escaped, %0d inside.",
			colors_seen, settings, colors_escaped, colors_seen - colors_escaped);
		$display("Limits 0 to 4095, saturated mapping and orbits, gains 0 to 255, %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0 && colors_owed == 0)
			$display("PASS mandelbrot_escape_color_pixel");
		else
			$display("FAIL mandelbrot_escape_color_pixel");
		$finish;
	end

endmodule
